/* design/sector_interleave_skew_mapper_macros.svh */
`ifndef SECTOR_INTERLEAVE_SKEW_MAPPER_MACROS_SVH
`define SECTOR_INTERLEAVE_SKEW_MAPPER_MACROS_SVH

// Same-cycle implication, sampled on the rising edge, off while in reset.
`define SISM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising edge, off while in reset.
`define SISM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/sism_pkg.sv */
`default_nettype none

package sism_pkg;

    localparam int MAX_SPT    = 256;
    localparam int SECT_W     = 24;
    localparam int SPT_W      = 9;
    localparam int ILV_W      = 8;
    localparam int TSKEW_W    = 8;
    localparam int SLOT_W     = (MAX_SPT > 1) ? $clog2(MAX_SPT) : 1;
    localparam int CNT_W      = SLOT_W + 1;
    localparam int PSUM_W     = ((SLOT_W > ILV_W) ? SLOT_W : ILV_W) + 1;
    localparam int BIT_W      = $clog2(TSKEW_W);
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;

    localparam logic [SPT_W-1:0]   SPT_RESET   = SPT_W'(26);
    localparam logic [ILV_W-1:0]   ILV_RESET   = ILV_W'(1);
    localparam logic [TSKEW_W-1:0] TSKEW_RESET = '0;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SPT   = 2'd0,
        REG_ILV   = 2'd1,
        REG_TSKEW = 2'd2
    } sism_reg_t;

    // Map builder status toward the item path
    typedef struct packed {
        logic              done;
        logic              inv_we;
        logic [SLOT_W-1:0] inv_addr;
        logic [SLOT_W-1:0] inv_data;
        logic [SLOT_W-1:0] skew_step;
    } sism_bld_t;

    // Zero counts as one, large values saturate
    function automatic logic [CNT_W-1:0] eff_spt(input logic [SPT_W-1:0] spt);
        if (spt == '0)
            return CNT_W'(1);
        if (spt > SPT_W'(MAX_SPT))
            return CNT_W'(MAX_SPT);
        return CNT_W'(spt);
    endfunction

endpackage

`default_nettype wire

/* design/sism_ifs.sv */
`default_nettype none

interface sism_cfg_if;
    import sism_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

interface sism_req_if;
    import sism_pkg::*;
    logic              valid;
    logic              ready;
    logic              start_req;
    logic [SECT_W-1:0] from_sector;
    logic [SECT_W-1:0] to_sector;
    modport source (output valid, output start_req, output from_sector, output to_sector,
                    input ready);
    modport sink   (input valid, input start_req, input from_sector, input to_sector,
                    output ready);
endinterface

interface sism_rsp_if;
    import sism_pkg::*;
    logic              valid;
    logic              ready;
    logic [SECT_W-1:0] source_sector;
    logic              valid_res;
    logic              last;
    modport source (output valid, output source_sector, output valid_res, output last,
                    input ready);
    modport sink   (input valid, input source_sector, input valid_res, input last,
                    output ready);
endinterface

`default_nettype wire

/* design/sism_ram.sv */
`default_nettype none

module sism_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

/* design/sism_builder.sv */
`default_nettype none

module sism_builder (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    input  wire logic [sism_pkg::CNT_W-1:0]   s_eff,
    input  wire logic [sism_pkg::ILV_W-1:0]   step,
    input  wire logic [sism_pkg::TSKEW_W-1:0] skew,
    output      sism_pkg::sism_bld_t          bld
);
    import sism_pkg::*;

    typedef enum logic [2:0] {
        B_IDLE,
        B_MOD,
        B_CLEAR,
        B_MARK,
        B_PROBE,
        B_CHECK
    } bld_state_t;

    bld_state_t        state_reg;
    logic [BIT_W-1:0]  bit_reg;
    logic [SLOT_W-1:0] rem_reg;
    logic [CNT_W-1:0]  idx_reg;
    logic [CNT_W-1:0]  n_reg;
    logic [SLOT_W-1:0] pos_reg;
    logic              done_reg;

    logic [ILV_W-1:0]  step_eff;
    logic [CNT_W-1:0]  rem_shift;
    logic [SLOT_W-1:0] rem_next;
    logic [PSUM_W-1:0] pos_jump;
    logic [CNT_W-1:0]  pos_inc;
    logic              taken_we;
    logic [SLOT_W-1:0] taken_waddr;
    logic              taken_wdata;
    logic              taken_re;
    logic              taken_rdata;

    assign step_eff  = (step == '0) ? ILV_W'(1) : step;

    // track_skew mod S, restoring division, one dividend bit per cycle
    assign rem_shift = {rem_reg, skew[bit_reg]};
    assign rem_next  = (rem_shift >= s_eff) ? SLOT_W'(rem_shift - s_eff)
                                            : rem_shift[SLOT_W-1:0];

    assign pos_jump  = PSUM_W'(pos_reg) + PSUM_W'(step_eff);
    assign pos_inc   = CNT_W'(pos_reg) + CNT_W'(1);

    assign taken_we    = (state_reg == B_CLEAR) || (state_reg == B_MARK);
    assign taken_waddr = (state_reg == B_CLEAR) ? idx_reg[SLOT_W-1:0] : pos_reg;
    assign taken_wdata = (state_reg == B_MARK);
    assign taken_re    = (state_reg == B_PROBE);

    sism_ram #(
        .WIDTH (1),
        .DEPTH (MAX_SPT)
    ) u_taken (
        .clk   (clk),
        .we    (taken_we),
        .waddr (taken_waddr),
        .wdata (taken_wdata),
        .re    (taken_re),
        .raddr (pos_reg),
        .rdata (taken_rdata)
    );

    assign bld.done      = done_reg;
    assign bld.inv_we    = (state_reg == B_MARK);
    assign bld.inv_addr  = n_reg[SLOT_W-1:0];
    assign bld.inv_data  = pos_reg;
    assign bld.skew_step = rem_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
            bit_reg   <= '0;
            rem_reg   <= '0;
            idx_reg   <= '0;
            n_reg     <= '0;
            pos_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                B_IDLE:
                begin
                    if (start)
                    begin
                        bit_reg   <= BIT_W'(TSKEW_W - 1);
                        rem_reg   <= '0;
                        state_reg <= B_MOD;
                    end
                end
                B_MOD:
                begin
                    rem_reg <= rem_next;
                    bit_reg <= bit_reg - BIT_W'(1);
                    if (bit_reg == '0)
                    begin
                        idx_reg   <= '0;
                        state_reg <= B_CLEAR;
                    end
                end
                B_CLEAR:
                begin
                    idx_reg <= idx_reg + CNT_W'(1);
                    if (idx_reg + CNT_W'(1) == s_eff)
                    begin
                        n_reg     <= '0;
                        pos_reg   <= '0;
                        state_reg <= B_MARK;
                    end
                end
                B_MARK:
                begin
                    if (n_reg + CNT_W'(1) == s_eff)
                    begin
                        done_reg  <= 1'b1;
                        state_reg <= B_IDLE;
                    end
                    else
                    begin
                        n_reg     <= n_reg + CNT_W'(1);
                        pos_reg   <= (pos_jump >= PSUM_W'(s_eff)) ? '0
                                                                  : pos_jump[SLOT_W-1:0];
                        state_reg <= B_PROBE;
                    end
                end
                B_PROBE:
                begin
                    state_reg <= B_CHECK;
                end
                B_CHECK:
                begin
                    if (taken_rdata)
                    begin
                        pos_reg   <= (pos_inc >= s_eff) ? '0 : pos_inc[SLOT_W-1:0];
                        state_reg <= B_PROBE;
                    end
                    else
                    begin
                        state_reg <= B_MARK;
                    end
                end
                default:
                begin
                    state_reg <= B_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

/* design/sector_interleave_skew_mapper.sv */
// Channel | Dir | Payload                                  | Handshake
// cfg     | in  | index (2), data (9)                      | valid/ready, ready always high
// req     | in  | start_req, from_sector (24), to_sector   | valid/ready
// rsp     | out | source_sector (24), valid_res, last      | valid/ready, output register
//
// Items: each is accepted with the map read issued, then looked up and updated once
//   the result register is free or drains; req is not taken during the lookup.
// Map build, on the first start after reset or a register write: track_skew mod S
//   one bit at a time, a pass clearing the slot flags, then one mark per slot with
//   probes of the free-slot search between, then the first map read.
// Reset: asynchronous, registers back to 26/1/0, map invalid, no clearing pass.
// Stalls: req is taken while a result waits; the lookup then holds until rsp drains.

`default_nettype none

module sector_interleave_skew_mapper (
    input  wire logic  clk,
    input  wire logic  rst_n,
    sism_cfg_if.sink   cfg,
    sism_req_if.sink   req,
    sism_rsp_if.source rsp
);
    import sism_pkg::*;

    typedef enum logic [1:0] {
        T_IDLE,
        T_BUILD,
        T_LOOKUP
    } top_state_t;

    top_state_t         state_reg;

    // configuration registers
    logic [SPT_W-1:0]   spt_reg;
    logic [ILV_W-1:0]   ilv_reg;
    logic [TSKEW_W-1:0] tskew_reg;

    // transfer state
    logic               map_valid_reg;
    logic               active_reg;
    logic [SECT_W-1:0]  track_base_reg;
    logic [SECT_W-1:0]  end_sector_reg;
    logic [CNT_W-1:0]   slot_index_reg;
    logic [SLOT_W-1:0]  skew_off_reg;

    // result register
    logic               rsp_vld_reg;
    logic [SECT_W-1:0]  source_sector_reg;
    logic               valid_res_reg;
    logic               last_reg;

    logic               cfg_acc;
    logic               req_acc;
    logic               need_build;
    logic               bld_start;
    sism_bld_t          bld;

    logic [CNT_W-1:0]   s_eff;
    logic [CNT_W-1:0]   slot_wrap;
    logic               inv_re;
    logic [SLOT_W-1:0]  inv_raddr;
    logic [SLOT_W-1:0]  inv_rdata;

    logic [CNT_W-1:0]   pos_sum;
    logic [CNT_W-1:0]   pos;
    logic [SECT_W:0]    here_next;
    logic               fin;
    logic [SECT_W-1:0]  src_sector;
    logic [CNT_W-1:0]   slot_inc;
    logic               track_end;
    logic [SECT_W-1:0]  base_next;
    logic [CNT_W-1:0]   skew_sum;
    logic [SLOT_W-1:0]  skew_next;
    logic               lk_load;

    assign s_eff      = eff_spt(spt_reg);

    assign cfg.ready  = 1'b1;
    assign cfg_acc    = cfg.valid && cfg.ready;
    assign req.ready  = (state_reg == T_IDLE);
    assign req_acc    = req.valid && req.ready;
    assign need_build = req.start_req && !map_valid_reg;
    assign bld_start  = req_acc && need_build;

    sism_builder u_builder (
        .clk   (clk),
        .rst_n (rst_n),
        .start (bld_start),
        .s_eff (s_eff),
        .step  (ilv_reg),
        .skew  (tskew_reg),
        .bld   (bld)
    );

    // A slot index left at or past S (S shrank) restarts the track at slot 0.
    assign slot_wrap = (slot_index_reg >= s_eff) ? '0 : slot_index_reg;

    // Map read goes out on accept, or right after the build for a fresh start
    // (slot 0 in both start cases).
    assign inv_re    = (req_acc && !need_build) || ((state_reg == T_BUILD) && bld.done);
    assign inv_raddr = ((state_reg == T_IDLE) && !req.start_req) ? slot_wrap[SLOT_W-1:0]
                                                                  : '0;

    sism_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (MAX_SPT)
    ) u_inv_map (
        .clk   (clk),
        .we    (bld.inv_we),
        .waddr (bld.inv_addr),
        .wdata (bld.inv_data),
        .re    (inv_re),
        .raddr (inv_raddr),
        .rdata (inv_rdata)
    );

    // in-track position with skew, one conditional subtract since both are below S
    assign pos_sum    = CNT_W'(inv_rdata) + CNT_W'(skew_off_reg);
    assign pos        = (pos_sum >= s_eff) ? (pos_sum - s_eff) : pos_sum;
    assign src_sector = track_base_reg + SECT_W'(pos);

    // transfer ends once the linear position reaches to_sector, mid-track or not
    assign here_next  = (SECT_W+1)'(track_base_reg) + (SECT_W+1)'(slot_wrap)
                        + (SECT_W+1)'(1);
    assign fin        = (here_next >= (SECT_W+1)'(end_sector_reg));

    assign slot_inc   = slot_wrap + CNT_W'(1);
    assign track_end  = (slot_inc >= s_eff);
    assign base_next  = track_base_reg + SECT_W'(s_eff);
    assign skew_sum   = CNT_W'(skew_off_reg) + CNT_W'(bld.skew_step);
    assign skew_next  = (skew_sum >= s_eff) ? SLOT_W'(skew_sum - s_eff)
                                            : skew_sum[SLOT_W-1:0];

    assign lk_load    = (state_reg == T_LOOKUP) && (!rsp_vld_reg || rsp.ready);

    assign rsp.valid         = rsp_vld_reg;
    assign rsp.source_sector = source_sector_reg;
    assign rsp.valid_res     = valid_res_reg;
    assign rsp.last          = last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= T_IDLE;
            spt_reg           <= SPT_RESET;
            ilv_reg           <= ILV_RESET;
            tskew_reg         <= TSKEW_RESET;
            map_valid_reg     <= 1'b0;
            active_reg        <= 1'b0;
            track_base_reg    <= '0;
            end_sector_reg    <= '0;
            slot_index_reg    <= '0;
            skew_off_reg      <= '0;
            rsp_vld_reg       <= 1'b0;
            source_sector_reg <= '0;
            valid_res_reg     <= 1'b0;
            last_reg          <= 1'b0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                rsp_vld_reg <= 1'b0;
            end

            case (state_reg)
                T_IDLE:
                begin
                    if (req_acc)
                    begin
                        if (req.start_req)
                        begin
                            track_base_reg <= req.from_sector;
                            end_sector_reg <= req.to_sector;
                            slot_index_reg <= '0;
                            skew_off_reg   <= '0;
                            active_reg     <= (req.from_sector < req.to_sector);
                        end
                        state_reg <= need_build ? T_BUILD : T_LOOKUP;
                    end
                end
                T_BUILD:
                begin
                    if (bld.done)
                    begin
                        map_valid_reg <= 1'b1;
                        state_reg     <= T_LOOKUP;
                    end
                end
                T_LOOKUP:
                begin
                    if (lk_load)
                    begin
                        rsp_vld_reg <= 1'b1;
                        state_reg   <= T_IDLE;
                        if (active_reg)
                        begin
                            source_sector_reg <= src_sector;
                            valid_res_reg     <= 1'b1;
                            last_reg          <= fin;
                            slot_index_reg    <= slot_wrap;
                            if (fin)
                            begin
                                active_reg <= 1'b0;
                            end
                            else if (track_end)
                            begin
                                track_base_reg <= base_next;
                                slot_index_reg <= '0;
                                skew_off_reg   <= skew_next;
                                if (base_next >= end_sector_reg)
                                begin
                                    active_reg <= 1'b0;
                                end
                            end
                            else
                            begin
                                slot_index_reg <= slot_inc;
                            end
                        end
                        else
                        begin
                            source_sector_reg <= '0;
                            valid_res_reg     <= 1'b0;
                            last_reg          <= 1'b0;
                        end
                    end
                end
                default:
                begin
                    state_reg <= T_IDLE;
                end
            endcase

            // a register write drops the map and any running transfer
            if (cfg_acc)
            begin
                case (cfg.index)
                    REG_SPT:
                    begin
                        spt_reg       <= cfg.data[SPT_W-1:0];
                        map_valid_reg <= 1'b0;
                        active_reg    <= 1'b0;
                    end
                    REG_ILV:
                    begin
                        ilv_reg       <= cfg.data[ILV_W-1:0];
                        map_valid_reg <= 1'b0;
                        active_reg    <= 1'b0;
                    end
                    REG_TSKEW:
                    begin
                        tskew_reg     <= cfg.data[TSKEW_W-1:0];
                        map_valid_reg <= 1'b0;
                        active_reg    <= 1'b0;
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

endmodule

`default_nettype wire

/* design/sism_checker.sv */
`default_nettype none

`include "sector_interleave_skew_mapper_macros.svh"

module sism_assert_checker (
    input wire logic                        clk,
    input wire logic                        rst_n,
    input wire logic                        req_valid,
    input wire logic                        req_ready,
    input wire logic                        rsp_valid,
    input wire logic                        rsp_ready,
    input wire logic [sism_pkg::SECT_W-1:0] rsp_source_sector,
    input wire logic                        rsp_valid_res,
    input wire logic                        rsp_last
);
    import sism_pkg::*;

    // transactions taken on req whose result has not left on rsp
    logic [1:0] pend_reg;
    logic       req_acc;
    logic       rsp_acc;

    assign req_acc = req_valid && req_ready;
    assign rsp_acc = rsp_valid && rsp_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else
        begin
            pend_reg <= pend_reg + 2'(req_acc) - 2'(rsp_acc);
        end
    end

    `SISM_ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready,
        rsp_valid && $stable(rsp_source_sector) && $stable(rsp_valid_res)
        && $stable(rsp_last), "rsp transaction changed while stalled")
    `SISM_ASSERT_NOW(a_empty_zero, clk, rst_n, rsp_valid && !rsp_valid_res,
        rsp_source_sector == '0 && !rsp_last, "empty result carries data")
    `SISM_ASSERT_NOW(a_no_orphan, clk, rst_n, rsp_valid, pend_reg != 2'd0,
        "result without a pending request")
    `SISM_ASSERT_NOW(a_depth, clk, rst_n, pend_reg == 2'd2, !req_ready,
        "request taken with two results outstanding")

endmodule

bind sector_interleave_skew_mapper sism_assert_checker u_sism_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .req_valid         (req.valid),
    .req_ready         (req.ready),
    .rsp_valid         (rsp.valid),
    .rsp_ready         (rsp.ready),
    .rsp_source_sector (rsp.source_sector),
    .rsp_valid_res     (rsp.valid_res),
    .rsp_last          (rsp.last)
);

`default_nettype wire

/* test/sism_checker.sv */
`timescale 1ns / 100ps

module sism_checker (
    input  wire logic clk,
    input  wire logic rst_n,
    sism_cfg_if       cfg,
    sism_req_if       req,
    sism_rsp_if       rsp,
    output int        mismatches,
    output int        outstanding
);
    import sism_pkg::*;

    typedef struct packed {
        logic [SECT_W-1:0] sector;
        logic              hit;
        logic              last;
    } sector_rsp_t;

    // register shadows
    logic [SPT_W-1:0]   spt_reg;
    logic [ILV_W-1:0]   ilv_reg;
    logic [TSKEW_W-1:0] tskew_reg;

    // interleave map, slot -> logical sector, plus transfer state
    logic [7:0]        slot_to_sector [MAX_SPT];
    bit                map_built;
    bit                xfer_on;
    logic [SECT_W-1:0] base_q;
    logic [SECT_W-1:0] stop_q;
    int unsigned       slot_q;
    int unsigned       skew_q;

    sector_rsp_t expected_sectors [$];

    function automatic int unsigned track_len();
        if (spt_reg == '0)
            return 1;
        if (spt_reg > SPT_W'(MAX_SPT))
            return MAX_SPT;
        return int'(spt_reg);
    endfunction

    function automatic void build_interleave();
        int unsigned s;
        int unsigned step;
        int unsigned pos;
        int unsigned n;
        bit          taken [MAX_SPT];
        s    = track_len();
        step = (ilv_reg == '0) ? 1 : int'(ilv_reg);
        pos  = 0;
        foreach (taken[i])
            taken[i] = 1'b0;
        for (n = 0; n < s; n++)
        begin
            taken[pos]        = 1'b1;
            slot_to_sector[n] = pos[7:0];
            if (n + 1 == s)
                break;
            pos += step;
            if (pos >= s)
                pos = 0;
            while (taken[pos])
            begin
                pos++;
                if (pos >= s)
                    pos = 0;
            end
        end
        map_built = 1'b1;
    endfunction

    function automatic void apply_write(input logic [CFG_IDX_W-1:0]  idx,
                                        input logic [CFG_DATA_W-1:0] val);
        case (idx)
            REG_SPT:   spt_reg   = val[SPT_W-1:0];
            REG_ILV:   ilv_reg   = val[ILV_W-1:0];
            REG_TSKEW: tskew_reg = val[TSKEW_W-1:0];
            default:   return;
        endcase
        map_built = 1'b0;
        xfer_on   = 1'b0;
    endfunction

    // one result per request transaction
    function automatic sector_rsp_t map_sector(input bit                start,
                                               input logic [SECT_W-1:0] lo,
                                               input logic [SECT_W-1:0] hi);
        sector_rsp_t r;
        int unsigned s;
        int unsigned pos;
        logic [63:0] here;
        bit          fin;
        r = '0;
        s = track_len();
        if (start)
        begin
            if (!map_built)
                build_interleave();
            base_q  = lo;
            stop_q  = hi;
            slot_q  = 0;
            skew_q  = 0;
            xfer_on = (lo < hi);
        end
        if (!xfer_on)
            return r;
        if (slot_q >= s)
            slot_q = 0;
        pos = int'(slot_to_sector[slot_q]) + skew_q;
        if (pos >= s)
            pos -= s;
        here     = 64'(base_q) + 64'(slot_q);
        fin      = (here + 64'd1 >= 64'(stop_q));
        r.sector = base_q + SECT_W'(pos);
        r.hit    = 1'b1;
        r.last   = fin;
        if (fin)
            xfer_on = 1'b0;
        else if (slot_q + 1 >= s)
        begin
            base_q = base_q + SECT_W'(s);
            slot_q = 0;
            skew_q += int'(tskew_reg) % s;
            if (skew_q >= s)
                skew_q -= s;
            if (base_q >= stop_q)
                xfer_on = 1'b0;
        end
        else
            slot_q++;
        return r;
    endfunction

    function automatic void flag_error(input string msg);
        if (mismatches < 10)
            $display("%0t ns: %s", $time, msg);
        mismatches++;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        sector_rsp_t seen;
        sector_rsp_t want;
        if (!rst_n)
        begin
            spt_reg    = SPT_RESET;
            ilv_reg    = ILV_RESET;
            tskew_reg  = TSKEW_RESET;
            map_built  = 1'b0;
            xfer_on    = 1'b0;
            base_q     = '0;
            stop_q     = '0;
            slot_q     = 0;
            skew_q     = 0;
            mismatches = 0;
            expected_sectors.delete();
            outstanding <= 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
                apply_write(cfg.index, cfg.data);
            if (req.valid && req.ready)
                expected_sectors.push_back(map_sector(req.start_req, req.from_sector,
                                                      req.to_sector));
            if (rsp.valid && rsp.ready)
            begin
                seen = {rsp.source_sector, rsp.valid_res, rsp.last};
                if (expected_sectors.size() == 0)
                    flag_error($sformatf("result with none pending: sector %h valid_res %b last %b",
                                         seen.sector, seen.hit, seen.last));
                else
                begin
                    want = expected_sectors.pop_front();
                    if (seen.sector !== want.sector)
                        flag_error($sformatf("source_sector: expected %h, got %h",
                                             want.sector, seen.sector));
                    if (seen.hit !== want.hit)
                        flag_error($sformatf("valid_res: expected %b, got %b",
                                             want.hit, seen.hit));
                    if (seen.last !== want.last)
                        flag_error($sformatf("last: expected %b, got %b",
                                             want.last, seen.last));
                end
            end
            outstanding <= expected_sectors.size();
        end
    end

endmodule

/* test/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
    import sism_pkg::*;

    localparam int SECT_MAX   = (1 << SECT_W) - 1;
    localparam int TIMEOUT_NS = 20_000_000;   // far above the slowest run

    logic clk = 1'b0;
    logic rst_n;

    // idle odds in percent, per side
    int send_gap_pct   = 0;
    int recv_stall_pct = 0;

    int unsigned items_sent = 0;
    int unsigned cur_len    = 26;   // effective sectors per track, as last written
    int          mismatches;
    int          outstanding;

    sism_cfg_if cfg ();
    sism_req_if req ();
    sism_rsp_if rsp ();

    sector_interleave_skew_mapper dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .req   (req),
        .rsp   (rsp)
    );

    // predicts every request transaction and scores every response transaction
    sism_checker u_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .req         (req),
        .rsp         (rsp),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // receiver back-pressure, redrawn every cycle
    always @(posedge clk)
        rsp.ready <= rst_n && ($urandom_range(0, 99) >= recv_stall_pct);

    // hard stop if the handshake ever hangs
    initial
    begin
        #(TIMEOUT_NS);
        $display("Mismatches found");
        $finish;
    end

    function automatic logic [SECT_W-1:0] rnd_sector();
        return SECT_W'($urandom);
    endfunction

    // one request transaction; valid stays up across back-to-back items
    task automatic send_item(input bit                start,
                             input logic [SECT_W-1:0] lo,
                             input logic [SECT_W-1:0] hi);
        while ($urandom_range(0, 99) < send_gap_pct)
        begin
            req.valid <= 1'b0;
            @(posedge clk);
        end
        req.valid       <= 1'b1;
        req.start_req   <= start;
        req.from_sector <= lo;
        req.to_sector   <= hi;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        items_sent++;
    endtask

    // stop sending and let every expected result come back
    task automatic drain();
        req.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(input sism_reg_t idx, input logic [CFG_DATA_W-1:0] val);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= val;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
    endtask

    // only while idle: any write drops the map and the running transfer
    task automatic reconfigure(input int unsigned spt, input int unsigned ilv,
                               input int unsigned skew);
        drain();
        write_reg(REG_SPT, CFG_DATA_W'(spt));
        write_reg(REG_ILV, CFG_DATA_W'(ilv));
        write_reg(REG_TSKEW, CFG_DATA_W'(skew));
        cfg.valid <= 1'b0;
        cur_len = (spt == 0) ? 1 : ((spt > MAX_SPT) ? MAX_SPT : spt);
    endtask

    // Mostly whole transfers with random placement and length, some cut short by
    // a new start, plus raw starts with full-range random bounds and stray continues.
    task automatic run_traffic(input int unsigned budget);
        int unsigned       goal;
        int unsigned       pick;
        int unsigned       span;
        int unsigned       cut;
        int unsigned       cap;
        int unsigned       n;
        logic [SECT_W-1:0] lo;
        goal = items_sent + budget;
        while (items_sent < goal)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 5)
                send_item(1'b0, rnd_sector(), rnd_sector());
            else if (pick < 15)
            begin
                // mostly empty (from above to) or huge ranges, abandoned soon
                send_item(1'b1, rnd_sector(), rnd_sector());
                n = $urandom_range(0, 3);
                repeat (n) send_item(1'b0, rnd_sector(), rnd_sector());
            end
            else
            begin
                // near the top of the address space now and then, for the wrap
                if ($urandom_range(0, 9) == 0)
                    lo = SECT_W'(SECT_MAX - $urandom_range(0, cur_len + 4));
                else
                    lo = rnd_sector();
                cap = (cur_len < 20) ? 2 * cur_len + 3 : 40;
                if ($urandom_range(0, 9) == 0)
                    cap = (2 * cur_len + 3 < 300) ? 2 * cur_len + 3 : 300;
                span = $urandom_range(1, cap);
                if (span > SECT_MAX - lo)
                    span = SECT_MAX - lo;
                cut = span;
                if (span > 1 && $urandom_range(0, 9) == 0)
                    cut = $urandom_range(1, span - 1);
                send_item(1'b1, lo, lo + SECT_W'(span));
                for (n = 1; n < cut; n++)
                    send_item(1'b0, rnd_sector(), rnd_sector());
                // continues after the end must come back empty, unless the transfer was cut short
                if ($urandom_range(0, 4) == 0)
                begin
                    n = $urandom_range(1, 2);
                    repeat (n) send_item(1'b0, rnd_sector(), rnd_sector());
                end
            end
        end
    endtask

    initial
    begin : stimulus
        int unsigned spt_set  [10] = '{256, 0, 1, 256, 13, 7, 100, 2, 0, 0};
        int unsigned ilv_set  [10] = '{255, 0, 255, 3, 5, 2, 17, 1, 0, 0};
        int unsigned skew_set [10] = '{255, 0, 37, 7, 200, 3, 99, 1, 0, 0};
        int          ph;

        rst_n           = 1'b0;
        cfg.valid       = 1'b0;
        cfg.index       = REG_SPT;
        cfg.data        = '0;
        req.valid       = 1'b0;
        req.start_req   = 1'b0;
        req.from_sector = '0;
        req.to_sector   = '0;
        send_gap_pct    = 24;
        recv_stall_pct  = 58;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed, reset registers (26 sectors, interleave 1, no skew)
        send_item(1'b0, '0, SECT_W'(SECT_MAX));          // continue with nothing running
        send_item(1'b1, SECT_W'(5), SECT_W'(5));         // empty, equal bounds
        send_item(1'b1, SECT_W'(SECT_MAX), '0);          // empty, reversed bounds
        send_item(1'b1, '0, SECT_W'(1));                 // single sector
        send_item(1'b0, rnd_sector(), rnd_sector());     // after the end
        send_item(1'b1, SECT_W'(100), SECT_W'(103));
        send_item(1'b0, '0, '0);
        send_item(1'b0, '0, '0);
        send_item(1'b1, SECT_W'(200), SECT_W'(260));
        send_item(1'b0, '0, '0);
        send_item(1'b0, '0, '0);
        send_item(1'b1, SECT_W'(SECT_MAX - 1), SECT_W'(SECT_MAX));  // abandons the last one

        // short skewed tracks: sector wrap past the top and a short last track
        reconfigure(4, 2, 3);
        send_item(1'b1, SECT_W'(SECT_MAX - 6), SECT_W'(SECT_MAX));
        repeat (5) send_item(1'b0, rnd_sector(), rnd_sector());
        send_item(1'b1, '0, SECT_W'(6));
        repeat (5) send_item(1'b0, rnd_sector(), rnd_sector());

        // random phases, two of them with random registers
        spt_set[8]  = $urandom_range(0, MAX_SPT);
        ilv_set[8]  = $urandom_range(0, 255);
        skew_set[8] = $urandom_range(0, 255);
        spt_set[9]  = $urandom_range(0, 40);
        ilv_set[9]  = $urandom_range(0, 255);
        skew_set[9] = $urandom_range(0, 255);
        for (ph = 0; ph < 10; ph++)
        begin
            if (ph < 4)
            begin
                send_gap_pct   = 24;
                recv_stall_pct = 58;
            end
            else if (ph < 7)
            begin
                send_gap_pct   = 58;
                recv_stall_pct = 24;
            end
            else
            begin
                send_gap_pct   = 0;
                recv_stall_pct = 0;
            end
            reconfigure(spt_set[ph], ilv_set[ph], skew_set[ph]);
            run_traffic(50);
        end

        drain();
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+design
design/sism_pkg.sv
design/sism_ifs.sv
design/sism_ram.sv
design/sism_builder.sv
design/sector_interleave_skew_mapper.sv
design/sism_checker.sv
test/sism_checker.sv
test/tb_top.sv
